FILE: src/les_pkg.sv
package les_pkg;

  // LED matrix geometry
  localparam int LedCount = 14;
  localparam int DayCount = LedCount / 2;
  localparam int PhaseWidthDefault = 32;

  // command codes
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_LIVE = 2'd1;
  localparam logic [1:0] OP_IDLE = 2'd2;

  // effect modes
  localparam logic [2:0] M_OFF      = 3'd0;
  localparam logic [2:0] M_BREATHE  = 3'd1;
  localparam logic [2:0] M_BLINK    = 3'd2;
  localparam logic [2:0] M_MASKED   = 3'd3;
  localparam logic [2:0] M_PROGRESS = 3'd4;
  localparam logic [2:0] M_FIREWORK = 3'd5;

  localparam logic [6:0] MAX_LEVEL     = 7'd127;
  localparam logic [4:0] FADE_TICKS    = 5'd25;
  localparam logic [4:0] BLINK_PERIOD  = 5'd24;
  localparam logic [4:0] BLINK_HALF    = 5'd12;
  localparam logic [8:0] PROGRESS_STEP = 9'd50;
  localparam logic [2:0] LAST_COLUMN   = 3'd6;

  // ms to 20 ms ticks: (ms >> 2) / 5 by reciprocal multiply
  localparam logic [15:0] RECIP_FIVE = 16'd52429;

  // fade-in level 127*k/25 for k = 0..24
  localparam logic [6:0] FADE_LUT [25] = '{
    7'd0, 7'd5, 7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45,
    7'd50, 7'd55, 7'd60, 7'd66, 7'd71, 7'd76, 7'd81, 7'd86, 7'd91, 7'd96,
    7'd101, 7'd106, 7'd111, 7'd116, 7'd121
  };

  typedef struct packed {
    logic [LedCount-1:0] red;
    logic [LedCount-1:0] green;
    logic [LedCount-1:0] blink;
    logic [2:0]          days;
    logic [3:0]          center;
    logic                implode;
  } params_t;

  // map red/green LED masks onto the eight driver nibbles
  function automatic logic [31:0] show(input logic [LedCount-1:0] red,
                                       input logic [LedCount-1:0] green);
    logic [31:0] n;
    n = '0;
    for (int i = 0; i < LedCount; i++) begin
      if (red[i]) n[4 * ((((i >> 1) & 1) * 2) + (i & 1)) + (i >> 2)] = 1'b1;
      if (green[i]) n[4 * ((((i >> 1) & 1) * 2) + (i & 1) + 4) + (i >> 2)] = 1'b1;
    end
    return n;
  endfunction

endpackage

FILE: src/led_effect_sequencer_core.sv
// LED effect sequencer core for a 14-LED red/green matrix.
// Input channel: in_valid / in_stall carries one beat per command or tick.
//   op selects tick, set live effect or set idle effect; the other fields
//   hold the effect mode, its masks and parameters, and the duration in ms.
// Output channel: out_valid / out_stall carries one beat per tick with the
//   eight driver nibbles, the brightness and the effect-done flag. Commands
//   give no output beat.
// Path: a tick beat goes through the input register, then the result
//   register; a stall on the output can hold it between the two.
// Throughput: one beat per cycle while the output is not stalled; the
//   whole tick update, including any mode reset and expiry, is done
//   combinationally between the input register and the result register.
// Stall: while out_stall holds a result, the input register keeps its beat
//   and in_stall rises once it is full; nothing is lost or repeated.
// Reset: rst clears the valid flags of both registers and puts the
//   sequencer into the off effect, reset pending, brightness 127, LEDs dark.
module led_effect_sequencer_core
  import les_pkg::*;
#(
  parameter int PHASE_WIDTH = PhaseWidthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          op,
  input  logic [2:0]          mode,
  input  logic [LedCount-1:0] red_leds,
  input  logic [LedCount-1:0] green_leds,
  input  logic [LedCount-1:0] blink_leds,
  input  logic [2:0]          progress_days,
  input  logic [3:0]          center_led,
  input  logic                implode,
  input  logic [19:0]         duration,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          red_even_pm,
  output logic [3:0]          red_even_am,
  output logic [3:0]          red_odd_pm,
  output logic [3:0]          red_odd_am,
  output logic [3:0]          green_even_pm,
  output logic [3:0]          green_even_am,
  output logic [3:0]          green_odd_pm,
  output logic [3:0]          green_odd_am,
  output logic [6:0]          brightness,
  output logic                effect_done
);

  typedef struct packed {
    logic [2:0]             live_mode;
    params_t                live_par;
    logic [19:0]            live_dur;
    logic [15:0]            live_ticks;
    logic [2:0]             idle_mode;
    params_t                idle_par;
    logic                   pending;
    logic [2:0]             prev_mode;
    logic                   rising;
    logic [PHASE_WIDTH-1:0] phase;
    logic [1:0]             sub3;
    logic [7:0]             ring;
    logic [4:0]             b24;
    logic [15:0]            dticks;
    logic [15:0]            elapsed;
    logic [4:0]             fade;
    logic [6:0]             bright;
    logic [31:0]            nib;
  } state_t;

  // mode reset, applied on the first tick after a change
  function automatic state_t do_reset(input state_t s);
    state_t r;
    r = s;
    r.pending = 1'b0;
    r.elapsed = '0;
    r.dticks  = s.live_ticks;
    if (!(s.live_mode == M_PROGRESS && s.prev_mode == M_PROGRESS)) begin
      r.phase = '0;
      r.sub3  = '0;
      r.ring  = '0;
      r.b24   = '0;
    end
    if (s.fade != FADE_TICKS) r.fade = '0;
    case (s.live_mode) inside
      M_OFF: begin
        r.nib    = '0;
        r.bright = '0;
      end
      M_BREATHE: begin
        r.rising = 1'b1;
        r.nib    = show(s.live_par.red, s.live_par.green);
      end
      M_BLINK, M_MASKED, M_FIREWORK: begin
        r.bright = MAX_LEVEL;
        r.nib    = show(s.live_par.red, s.live_par.green);
      end
      M_PROGRESS: r.bright = MAX_LEVEL;
      default: ;
    endcase
    r.prev_mode = s.live_mode;
    return r;
  endfunction

  // phase step with the mod-24 and ring side counters kept in line
  function automatic state_t inc_phase(input state_t s);
    state_t r;
    r = s;
    if (&s.phase) begin
      r.phase = '0;
      r.sub3  = '0;
      r.ring  = '0;
      r.b24   = '0;
    end else begin
      r.phase = s.phase + 1'b1;
      r.b24   = (s.b24 == BLINK_PERIOD - 5'd1) ? 5'd0 : s.b24 + 5'd1;
      if (s.sub3 == 2'd2) begin
        r.sub3 = 2'd0;
        r.ring = s.ring + 8'd1;
      end else begin
        r.sub3 = s.sub3 + 2'd1;
      end
    end
    return r;
  endfunction

  state_t st, st_next;

  // input register
  logic       s1_valid;
  logic [1:0] s1_op;
  logic [2:0] s1_mode;
  params_t    s1_par;
  logic [19:0] s1_dur;
  logic       advance;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
    if (!in_stall) begin
      s1_op   <= op;
      s1_mode <= mode;
      s1_par  <= '{red: red_leds, green: green_leds, blink: blink_leds,
                   days: progress_days, center: center_led, implode: implode};
      s1_dur  <= duration;
    end
  end

  // duration in ticks for a live command
  logic [33:0] tick_prod;
  logic [15:0] s1_ticks;
  assign tick_prod = s1_dur[19:2] * RECIP_FIVE;
  assign s1_ticks  = tick_prod[33:18];

  // firework, progress, blink and fade helpers
  logic [2:0] fw_ccol;
  logic [3:0] fw_mc;
  logic [7:0] fw_x;
  logic [LedCount-1:0] fw_mask;
  logic [DayCount*2-1:0] pg_mask;
  logic [8:0] pg_target;
  logic       blink_lit;
  logic [LedCount-1:0] bl_red, bl_green;
  logic       tick_done;
  logic [4:0] fade_k;

  // sequencer update for the beat in the input register
  always_comb begin
    st_next   = st;
    tick_done = 1'b0;
    fw_ccol   = '0;
    fw_mc     = '0;
    fw_x      = '0;
    fw_mask   = '0;
    pg_mask   = '0;
    pg_target = '0;
    blink_lit = 1'b0;
    bl_red    = '0;
    bl_green  = '0;
    fade_k    = '0;
    if (advance) begin
      case (s1_op)
        OP_LIVE: begin
          if (!(st.live_mode == s1_mode && st.live_par == s1_par &&
                st.live_dur == s1_dur)) begin
            st_next.live_mode  = s1_mode;
            st_next.live_par   = s1_par;
            st_next.live_dur   = s1_dur;
            st_next.live_ticks = s1_ticks;
            st_next.pending    = 1'b1;
          end
        end
        OP_IDLE: begin
          if (st.idle_mode != s1_mode || st.idle_par != s1_par) begin
            st_next.idle_mode = s1_mode;
            st_next.idle_par  = s1_par;
            if (st.live_dur == '0 &&
                !(st.live_mode == s1_mode && st.live_par == s1_par)) begin
              st_next.live_mode  = s1_mode;
              st_next.live_par   = s1_par;
              st_next.live_ticks = '0;
              st_next.pending    = 1'b1;
            end
          end
        end
        OP_TICK: begin
          if (st_next.pending) st_next = do_reset(st_next);
          // duration countdown and expiry
          if (st_next.dticks != '0) begin
            st_next.elapsed = st_next.elapsed + 16'd1;
            if (st_next.elapsed >= st_next.dticks) begin
              if (!(st_next.live_mode == st_next.idle_mode &&
                    st_next.live_par == st_next.idle_par &&
                    st_next.live_dur == '0)) begin
                st_next.live_mode  = st_next.idle_mode;
                st_next.live_par   = st_next.idle_par;
                st_next.live_dur   = '0;
                st_next.live_ticks = '0;
                st_next.pending    = 1'b1;
              end
              tick_done = 1'b1;
              if (st_next.idle_mode != M_OFF && st_next.idle_mode != M_BREATHE)
                st_next.fade = FADE_TICKS;
              if (st_next.pending) st_next = do_reset(st_next);
            end
          end
          // animation step
          case (st_next.live_mode) inside
            M_BREATHE: begin
              if (st_next.phase >= PHASE_WIDTH'(MAX_LEVEL)) st_next.rising = 1'b0;
              else if (st_next.phase == '0) st_next.rising = 1'b1;
              st_next.phase  = st_next.rising ? st_next.phase + 1'b1
                                              : st_next.phase - 1'b1;
              st_next.bright = st_next.phase[6:0];
            end
            M_BLINK, M_MASKED: begin
              if (st_next.b24 == '0 || st_next.b24 == BLINK_HALF) begin
                blink_lit = (st_next.b24 == '0);
                bl_red    = st_next.live_par.red;
                bl_green  = st_next.live_par.green;
                if (!blink_lit) begin
                  if (st_next.live_mode == M_BLINK) begin
                    bl_red   = '0;
                    bl_green = '0;
                  end else begin
                    bl_red   = bl_red & ~st_next.live_par.blink;
                    bl_green = bl_green & ~st_next.live_par.blink;
                  end
                end
                st_next.nib = show(bl_red, bl_green);
              end
              st_next = inc_phase(st_next);
            end
            M_PROGRESS: begin
              pg_target = st_next.live_par.days * PROGRESS_STEP;
              if (st_next.phase < PHASE_WIDTH'(pg_target))
                st_next.phase = st_next.phase + 1'b1;
              else if (st_next.phase > PHASE_WIDTH'(pg_target))
                st_next.phase = st_next.phase - 1'b1;
              for (int c = 0; c < DayCount; c++) begin
                if (st_next.phase > PHASE_WIDTH'(c * 50)) pg_mask[2*c +: 2] = 2'b11;
              end
              st_next.nib = show(pg_mask & st_next.live_par.red,
                                 pg_mask & st_next.live_par.green);
            end
            M_FIREWORK: begin
              fw_ccol = st_next.live_par.center[3:1];
              fw_mc   = (fw_ccol > LAST_COLUMN - fw_ccol) ? {1'b0, fw_ccol}
                        : {1'b0, LAST_COLUMN - fw_ccol};
              fw_x    = st_next.live_par.implode
                        ? (8'(fw_mc) + 8'd1 - st_next.ring) : st_next.ring;
              if (!fw_x[7]) begin
                for (int i = 0; i < LedCount; i++) begin
                  if ((((3'(i >> 1) >= fw_ccol) ? 4'(3'(i >> 1) - fw_ccol)
                                                : 4'(fw_ccol - 3'(i >> 1)))
                       + 4'(1'(i & 1) ^ st_next.live_par.center[0]))
                      == fw_x[3:0] && fw_x[6:4] == '0)
                    fw_mask[i] = 1'b1;
                end
              end
              st_next.nib = show(fw_mask & st_next.live_par.red,
                                 fw_mask & st_next.live_par.green);
              st_next = inc_phase(st_next);
            end
            default: ;
          endcase
          // fade-in after expiry
          if (st_next.fade != '0) begin
            fade_k         = FADE_TICKS - st_next.fade;
            st_next.bright = FADE_LUT[fade_k];
            st_next.fade   = st_next.fade - 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{live_mode: M_OFF, live_par: '0, live_dur: '0, live_ticks: '0,
              idle_mode: M_OFF, idle_par: '0, pending: 1'b1, prev_mode: M_OFF,
              rising: 1'b1, phase: '0, sub3: '0, ring: '0, b24: '0,
              dticks: '0, elapsed: '0, fade: '0, bright: MAX_LEVEL, nib: '0};
    end else begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_op == OP_TICK) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && s1_op == OP_TICK) begin
      red_even_pm   <= st_next.nib[3:0];
      red_even_am   <= st_next.nib[7:4];
      red_odd_pm    <= st_next.nib[11:8];
      red_odd_am    <= st_next.nib[15:12];
      green_even_pm <= st_next.nib[19:16];
      green_even_am <= st_next.nib[23:20];
      green_odd_pm  <= st_next.nib[27:24];
      green_odd_am  <= st_next.nib[31:28];
      brightness    <= st_next.bright;
      effect_done   <= tick_done;
    end
  end

  // checks
  a_fade_range: assert property (@(posedge clk) disable iff (rst)
    st.fade <= FADE_TICKS)
    else $error("fade counter out of range");

  a_side_counters: assert property (@(posedge clk) disable iff (rst)
    st.sub3 != 2'd3 && st.b24 < BLINK_PERIOD)
    else $error("phase side counters out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room downstream");

endmodule

FILE: test/tb_led_effect_sequencer_core.sv
`timescale 1ns / 1ps

module tb_led_effect_sequencer_core;
  import les_pkg::*;

  localparam int WatchdogLimit = 5000;

  // one input beat
  typedef struct {
    logic [1:0]          op;
    logic [2:0]          mode;
    logic [LedCount-1:0] red;
    logic [LedCount-1:0] green;
    logic [LedCount-1:0] blink;
    logic [2:0]          days;
    logic [3:0]          center;
    logic                implode;
    logic [19:0]         dur;
  } cmd_t;

  // one output beat: nibbles packed with red_even_pm in the low bits
  typedef struct {
    logic [31:0] nibbles;
    logic [6:0]  level;
    logic        done;
  } frame_t;

  // directed row: a beat plus an optional typed-in frame
  typedef struct {
    cmd_t   cmd;
    bit     known;
    frame_t frame;
  } row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          op = OP_TICK;
  logic [2:0]          mode = M_OFF;
  logic [LedCount-1:0] red_leds = '0;
  logic [LedCount-1:0] green_leds = '0;
  logic [LedCount-1:0] blink_leds = '0;
  logic [2:0]          progress_days = '0;
  logic [3:0]          center_led = '0;
  logic                implode = 1'b0;
  logic [19:0]         duration = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [3:0]          red_even_pm, red_even_am, red_odd_pm, red_odd_am;
  logic [3:0]          green_even_pm, green_even_am, green_odd_pm, green_odd_am;
  logic [6:0]          brightness;
  logic                effect_done;

  led_effect_sequencer_core i_dut (.*);

  always #5 clk = ~clk;

  // sequencer mirror state
  logic [2:0]  sq_live_mode, sq_idle_mode, sq_prev_mode;
  params_t     sq_live_par, sq_idle_par;
  logic [19:0] sq_live_dur;
  bit          sq_pending, sq_rising;
  logic [31:0] sq_phase;
  logic [15:0] sq_dur_ticks, sq_elapsed;
  int          sq_fade;
  logic [6:0]  sq_level;
  logic [31:0] sq_nibbles;

  frame_t frames_due[$];
  int     fail_count = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     quiet_cycles = 0;

  function automatic logic [31:0] led_map(logic [LedCount-1:0] r, logic [LedCount-1:0] g);
    logic [31:0] n;
    int          day, slot;
    n = '0;
    for (int i = 0; i < LedCount; i++) begin
      day = i / 2;
      slot = (day % 2) * 2 + i % 2;
      if (r[i]) n[4 * slot + day / 2] = 1'b1;
      if (g[i]) n[4 * (slot + 4) + day / 2] = 1'b1;
    end
    return n;
  endfunction

  function automatic void seq_clear();
    sq_live_mode = M_OFF;
    sq_idle_mode = M_OFF;
    sq_prev_mode = M_OFF;
    sq_live_par = '0;
    sq_idle_par = '0;
    sq_live_dur = '0;
    sq_pending = 1;
    sq_rising = 1;
    sq_phase = '0;
    sq_dur_ticks = '0;
    sq_elapsed = '0;
    sq_fade = 0;
    sq_level = MAX_LEVEL;
    sq_nibbles = '0;
  endfunction

  function automatic void seq_set_live(logic [2:0] m, params_t p, logic [19:0] d);
    if (sq_live_mode == m && sq_live_par == p && sq_live_dur == d) return;
    sq_live_mode = m;
    sq_live_par = p;
    sq_live_dur = d;
    sq_pending = 1;
  endfunction

  // restart of the live mode
  function automatic void seq_restart();
    sq_pending = 0;
    sq_elapsed = '0;
    sq_dur_ticks = 16'(sq_live_dur / 20);
    if (!(sq_live_mode == M_PROGRESS && sq_prev_mode == M_PROGRESS)) sq_phase = '0;
    if (sq_fade != 25) sq_fade = 0;
    case (sq_live_mode)
      M_OFF: begin
        sq_nibbles = '0;
        sq_level = '0;
      end
      M_BREATHE: begin
        sq_rising = 1;
        sq_nibbles = led_map(sq_live_par.red, sq_live_par.green);
      end
      M_BLINK, M_MASKED, M_FIREWORK: begin
        sq_level = MAX_LEVEL;
        sq_nibbles = led_map(sq_live_par.red, sq_live_par.green);
      end
      M_PROGRESS: sq_level = MAX_LEVEL;
      default: ;
    endcase
    sq_prev_mode = sq_live_mode;
  endfunction

  // one animation step of the live mode
  function automatic void seq_animate();
    params_t             p;
    logic [LedCount-1:0] r, g, m;
    int                  target, lit, ccol, crow, mc, mr, ring, x, t, dc, dr;
    p = sq_live_par;
    case (sq_live_mode)
      M_BREATHE: begin
        if (sq_phase >= 127) sq_rising = 0;
        else if (sq_phase == 0) sq_rising = 1;
        sq_phase = sq_rising ? sq_phase + 1 : sq_phase - 1;
        sq_level = sq_phase[6:0];
      end
      M_BLINK, M_MASKED: begin
        if (sq_phase % 12 == 0) begin
          r = p.red;
          g = p.green;
          if ((sq_phase / 12) % 2 != 0) begin
            if (sq_live_mode == M_BLINK) begin
              r = '0;
              g = '0;
            end else begin
              r &= ~p.blink;
              g &= ~p.blink;
            end
          end
          sq_nibbles = led_map(r, g);
        end
        sq_phase = sq_phase + 1;
      end
      M_PROGRESS: begin
        target = p.days * 50;
        if (sq_phase < target) sq_phase = sq_phase + 1;
        else if (sq_phase > target) sq_phase = sq_phase - 1;
        lit = (sq_phase > 0) ? (sq_phase - 1) / 50 + 1 : 0;
        m = '0;
        for (int i = 0; i < LedCount; i++) if (i / 2 < lit) m[i] = 1'b1;
        sq_nibbles = led_map(m & p.red, m & p.green);
      end
      M_FIREWORK: begin
        ccol = p.center / 2;
        crow = p.center % 2;
        mc = (ccol > 6 - ccol) ? ccol : 6 - ccol;
        mr = (crow > 1 - crow) ? crow : 1 - crow;
        ring = (sq_phase / 3) % 256;
        x = p.implode ? mc + mr - ring : ring;
        t = ((x % 256) + 256) % 256;
        if (t >= 128) t -= 256;
        m = '0;
        if (t >= 0)
          for (int i = 0; i < LedCount; i++) begin
            dc = i / 2 - ccol;
            dr = i % 2 - crow;
            if (dc < 0) dc = -dc;
            if (dr < 0) dr = -dr;
            if (dc + dr == t) m[i] = 1'b1;
          end
        sq_nibbles = led_map(m & p.red, m & p.green);
        sq_phase = sq_phase + 1;
      end
      default: ;
    endcase
  endfunction

  // advance the mirror by one beat; returns 1 when a frame is due
  function automatic bit seq_step(cmd_t c, output frame_t f);
    params_t p;
    p.red = c.red;
    p.green = c.green;
    p.blink = c.blink;
    p.days = c.days;
    p.center = c.center;
    p.implode = c.implode;
    f.done = 1'b0;
    if (c.op == OP_LIVE) begin
      seq_set_live(c.mode, p, c.dur);
      return 0;
    end
    if (c.op == OP_IDLE) begin
      if (sq_idle_mode != c.mode || sq_idle_par != p) begin
        sq_idle_mode = c.mode;
        sq_idle_par = p;
        if (sq_live_dur == 0) seq_set_live(c.mode, p, '0);
      end
      return 0;
    end
    if (c.op != OP_TICK) return 0;
    if (sq_pending) seq_restart();
    if (sq_dur_ticks > 0) begin
      sq_elapsed = sq_elapsed + 16'd1;
      if (sq_elapsed >= sq_dur_ticks) begin
        seq_set_live(sq_idle_mode, sq_idle_par, '0);
        f.done = 1'b1;
        if (sq_idle_mode != M_OFF && sq_idle_mode != M_BREATHE) sq_fade = 25;
        if (sq_pending) seq_restart();
      end
    end
    seq_animate();
    if (sq_fade > 0) begin
      sq_level = 7'((127 * (25 - sq_fade)) / 25);
      sq_fade--;
    end
    f.nibbles = sq_nibbles;
    f.level = sq_level;
    return 1;
  endfunction

  // output side: random stall and compare against the oldest expected frame
  always @(posedge clk) begin
    frame_t want;
    logic [31:0] got;
    if (!rst && out_valid && !out_stall) begin
      got = {green_odd_am, green_odd_pm, green_even_am, green_even_pm,
             red_odd_am, red_odd_pm, red_even_am, red_even_pm};
      if (frames_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected frame nibbles=%h level=%0d", got, brightness);
      end else begin
        want = frames_due.pop_front();
        if (got !== want.nibbles || brightness !== want.level || effect_done !== want.done) begin
          fail_count++;
          if (fail_count <= 10)
            $display("frame mismatch: expected nibbles=%h level=%0d done=%0d, got %h %0d %0d",
                     want.nibbles, want.level, want.done, got, brightness, effect_done);
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on beats moving through either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("led_effect_sequencer_core regression: fail");
      $finish;
    end
  end

  // present one beat, wait for it to be taken, and queue any frame it is due
  task automatic push_beat(cmd_t c, bit known, frame_t typed);
    frame_t f;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= c.op;
    mode <= c.mode;
    red_leds <= c.red;
    green_leds <= c.green;
    blink_leds <= c.blink;
    progress_days <= c.days;
    center_led <= c.center;
    implode <= c.implode;
    duration <= c.dur;
    do @(posedge clk); while (in_stall);
    if (seq_step(c, f)) frames_due.push_back(known ? typed : f);
  endtask

  function automatic cmd_t mk(logic [1:0] o, logic [2:0] m, logic [13:0] r, logic [13:0] g,
                              logic [13:0] b, logic [2:0] d, logic [3:0] ctr, logic imp,
                              logic [19:0] ms);
    cmd_t c;
    c = '{o, m, r, g, b, d, ctr, imp, ms};
    return c;
  endfunction

  function automatic cmd_t rand_cmd(cmd_t last_live);
    cmd_t c;
    int   k;
    k = $urandom_range(99);
    c = mk(OP_TICK, 3'($urandom_range(5)), 14'($urandom), 14'($urandom), 14'($urandom),
           3'($urandom), 4'($urandom_range(13)), 1'($urandom), '0);
    if ($urandom_range(19) == 0) c.mode = 3'($urandom_range(7));
    if ($urandom_range(29) == 0) c.center = 4'($urandom);
    case ($urandom_range(9))
      0, 1, 2: c.dur = '0;
      3, 4, 5, 6: c.dur = 20'($urandom_range(600, 20));
      7: c.dur = 20'($urandom_range(19, 1));
      8: c.dur = 20'($urandom);
      default: c.dur = 20'($urandom_range(4000, 20));
    endcase
    if (k < 8) c.op = OP_LIVE;
    else if (k < 10) c = last_live;
    else if (k < 15) c.op = OP_IDLE;
    else if (k < 17) c.op = 2'd3;
    return c;
  endfunction

  initial begin
    row_t   rows[$];
    cmd_t   last_live;
    frame_t none;
    none = '{'0, '0, 1'b0};
    seq_clear();

    rows.push_back('{mk(OP_TICK, M_OFF, 0, 0, 0, 0, 0, 0, 0), 1, '{32'h0, 7'd0, 1'b0}});
    rows.push_back('{mk(OP_LIVE, M_BLINK, '1, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_TICK, M_OFF, 0, 0, 0, 0, 0, 0, 0), 1,
                     '{32'h0000_77FF, 7'd127, 1'b0}});
    rows.push_back('{mk(OP_IDLE, M_BREATHE, '1, '1, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_TICK, M_OFF, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_LIVE, M_PROGRESS, '1, '1, 0, 7, 0, 0, 40), 0, none});
    rows.push_back('{mk(OP_TICK, M_OFF, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_TICK, M_OFF, 0, 0, 0, 0, 0, 0, 0), 0, none});
    // centre outside the matrix with a short duration that never expires
    rows.push_back('{mk(OP_LIVE, M_FIREWORK, '1, '1, 0, 0, 15, 1, 19), 0, none});
    rows.push_back('{mk(OP_TICK, M_OFF, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_IDLE, M_MASKED, '1, 0, '1, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(2'd3, 3'd7, '1, '1, '1, 7, 15, 1, '1), 0, none});
    rows.push_back('{mk(OP_LIVE, 3'd7, 0, 0, 0, 0, 0, 0, '1), 0, none});
    rows.push_back('{mk(OP_TICK, M_OFF, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_LIVE, 3'd6, '1, '1, '1, 7, 15, 1, '1), 0, none});
    rows.push_back('{mk(OP_TICK, '1, '1, '1, '1, '1, '1, 1, '1), 0, none});
    rows.push_back('{mk(OP_LIVE, M_MASKED, '1, '1, '1, 0, 0, 0, 0), 0, none});
    for (int i = 0; i < 3; i++)
      rows.push_back('{mk(OP_TICK, M_OFF, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_IDLE, M_OFF, 0, 0, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(OP_LIVE, M_FIREWORK, '1, '1, 0, 0, 0, 0, 20), 0, none});
    // expiry into the off idle effect: dark, brightness 0, done flagged
    rows.push_back('{mk(OP_TICK, M_OFF, 0, 0, 0, 0, 0, 0, 0), 1, '{32'h0, 7'd0, 1'b1}});
    rows.push_back('{mk(OP_LIVE, M_FIREWORK, '1, '1, 0, 0, 0, 0, 20), 0, none});
    rows.push_back('{mk(OP_TICK, M_OFF, 0, 0, 0, 0, 0, 0, 0), 0, none});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) push_beat(rows[i].cmd, rows[i].known, rows[i].frame);

    // random beats over the idle and stall phases
    last_live = rows[1].cmd;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 12 : 53) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 12 : 53) : 0;
      for (int n = 0; n < 445; n++) begin
        cmd_t c;
        c = rand_cmd(last_live);
        if (c.op == OP_LIVE) last_live = c;
        push_beat(c, 0, none);
      end
    end
    in_valid <= 1'b0;
    stall_pct = 0;

    while (frames_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("led_effect_sequencer_core regression: pass");
    else $display("led_effect_sequencer_core regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/les_pkg.sv
src/led_effect_sequencer_core.sv
test/tb_led_effect_sequencer_core.sv
